// ----- rtl/core/stl_pkg.sv -----
// Shared types, token codes and helper functions for the script token lexer.
package stl_pkg;

	localparam int OFFSET_BITS = 20;
	localparam int LINE_BITS   = 16;
	localparam int NEST_BITS   = 8;
	localparam int KEYWORD_MAX = 8;
	localparam int KIND_BITS   = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int ITEMS_MAX   = 3;

	typedef logic [OFFSET_BITS-1:0] off_t;
	typedef logic [OFFSET_BITS:0]   offx_t;
	typedef logic [LINE_BITS-1:0]   line_t;
	typedef logic [NEST_BITS-1:0]   nest_t;
	typedef logic [KIND_BITS-1:0]   kind_t;

	// Token kinds
	localparam kind_t K_END       = 6'd0;
	localparam kind_t K_NEWLINE   = 6'd1;
	localparam kind_t K_ILLEGAL   = 6'd2;
	localparam kind_t K_IDENT     = 6'd3;
	localparam kind_t K_INT       = 6'd4;
	localparam kind_t K_FLOAT     = 6'd5;
	localparam kind_t K_STRING    = 6'd6;
	localparam kind_t K_ASSIGN    = 6'd7;
	localparam kind_t K_EQ        = 6'd8;
	localparam kind_t K_PLUS      = 6'd9;
	localparam kind_t K_MINUS     = 6'd10;
	localparam kind_t K_STAR      = 6'd11;
	localparam kind_t K_SLASH     = 6'd12;
	localparam kind_t K_PERCENT   = 6'd13;
	localparam kind_t K_NOT       = 6'd14;
	localparam kind_t K_NEQ       = 6'd15;
	localparam kind_t K_LT        = 6'd16;
	localparam kind_t K_LTE       = 6'd17;
	localparam kind_t K_GT        = 6'd18;
	localparam kind_t K_GTE       = 6'd19;
	localparam kind_t K_AND       = 6'd20;
	localparam kind_t K_OR        = 6'd21;
	localparam kind_t K_LPAREN    = 6'd22;
	localparam kind_t K_RPAREN    = 6'd23;
	localparam kind_t K_LBRACE    = 6'd24;
	localparam kind_t K_RBRACE    = 6'd25;
	localparam kind_t K_LBRACKET  = 6'd26;
	localparam kind_t K_RBRACKET  = 6'd27;
	localparam kind_t K_COMMA     = 6'd28;
	localparam kind_t K_DOT       = 6'd29;
	localparam kind_t K_COLON     = 6'd30;
	localparam kind_t K_SEMICOLON = 6'd31;
	localparam kind_t K_SAY       = 6'd32;
	localparam kind_t K_VAL       = 6'd33;
	localparam kind_t K_LET       = 6'd34;
	localparam kind_t K_FUNC      = 6'd35;
	localparam kind_t K_IF        = 6'd36;
	localparam kind_t K_ELSE      = 6'd37;
	localparam kind_t K_LOOP      = 6'd38;
	localparam kind_t K_WHILE     = 6'd39;
	localparam kind_t K_IN        = 6'd40;
	localparam kind_t K_TO        = 6'd41;
	localparam kind_t K_RETURN    = 6'd42;
	localparam kind_t K_CLOSC     = 6'd43;
	localparam kind_t K_FOR       = 6'd44;
	localparam kind_t K_BREAK     = 6'd45;
	localparam kind_t K_CONTINUE  = 6'd46;
	localparam kind_t K_BOOL      = 6'd47;

	// One result word
	typedef struct packed {
		kind_t      kind;
		line_t      line;
		line_t      column;
		off_t       offset;
		off_t       length;
		logic [7:0] data;
		logic       dvalid;
		logic       last;
	} tok_t;

	// All result words caused by one source byte
	typedef struct packed {
		logic [1:0]                count;
		tok_t [ITEMS_MAX-1:0]      items;
	} bundle_t;

	// Span from start to end, zero if end is below start, saturated
	function automatic off_t tok_len(input offx_t end_pos, input off_t start);
		offx_t diff;
		diff = end_pos - {1'b0, start};
		if (end_pos < {1'b0, start})
			return '0;
		else if (diff[OFFSET_BITS])
			return '1;
		else
			return diff[OFFSET_BITS-1:0];
	endfunction

	// Pack a keyword literal with its first letter in the low byte
	function automatic logic [63:0] pack_kw(input logic [63:0] s, input int n);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < n)
				r[8*i +: 8] = s[8*(n-1-i) +: 8];
		end
		return r;
	endfunction

	function automatic logic kw_hit(input logic [63:0] w, input logic [3:0] len,
			input logic [63:0] s, input int n);
		return (len == 4'(n)) && (w == pack_kw(s, n));
	endfunction

	// Match a buffered word against the keyword list
	function automatic kind_t word_kind(input logic [63:0] w, input logic [3:0] len);
		kind_t k;
		k = K_IDENT;
		if (len <= 4'(KEYWORD_MAX)) begin
			if (kw_hit(w, len, 64'("say"), 3))      k = K_SAY;
			if (kw_hit(w, len, 64'("val"), 3))      k = K_VAL;
			if (kw_hit(w, len, 64'("let"), 3))      k = K_LET;
			if (kw_hit(w, len, 64'("func"), 4))     k = K_FUNC;
			if (kw_hit(w, len, 64'("if"), 2))       k = K_IF;
			if (kw_hit(w, len, 64'("else"), 4))     k = K_ELSE;
			if (kw_hit(w, len, 64'("loop"), 4))     k = K_LOOP;
			if (kw_hit(w, len, 64'("while"), 5))    k = K_WHILE;
			if (kw_hit(w, len, 64'("in"), 2))       k = K_IN;
			if (kw_hit(w, len, 64'("to"), 2))       k = K_TO;
			if (kw_hit(w, len, 64'("return"), 6))   k = K_RETURN;
			if (kw_hit(w, len, 64'("closc"), 5))    k = K_CLOSC;
			if (kw_hit(w, len, 64'("for"), 3))      k = K_FOR;
			if (kw_hit(w, len, 64'("break"), 5))    k = K_BREAK;
			if (kw_hit(w, len, 64'("continue"), 8)) k = K_CONTINUE;
			if (kw_hit(w, len, 64'("true"), 4))     k = K_BOOL;
			if (kw_hit(w, len, 64'("false"), 5))    k = K_BOOL;
		end
		return k;
	endfunction

	function automatic tok_t mk_tok(input kind_t kind, input line_t line, input line_t column,
			input off_t offset, input off_t length, input logic [7:0] data,
			input logic dvalid, input logic last);
		tok_t t;
		t.kind   = kind;
		t.line   = line;
		t.column = column;
		t.offset = offset;
		t.length = length;
		t.data   = data;
		t.dvalid = dvalid;
		t.last   = last;
		return t;
	endfunction

endpackage

// ----- rtl/core/script_token_lexer.sv -----
// Top level: streaming lexer, one source byte per word in, tokens out.
// Token words pass through the bundle queue and a registered back end to out_valid.
// Throughput: one source byte per cycle and one result word per cycle while out_stall
// is low; a byte that causes two or three words has them handed out one at a time,
// absorbed by a four-bundle queue before in_stall rises.
// Reset: arst_n clears all scanner state (line 1, column 0, offset 0) and empties the queue.
module script_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  kind,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic [19:0] start_offset,
	output logic [19:0] source_length,
	output logic [7:0]  data_byte,
	output logic        data_valid,
	output logic        last
);

	logic             accept, push, full, pop, empty;
	stl_pkg::bundle_t push_bundle, head;
	stl_pkg::tok_t    tok;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	stl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.push      (push),
		.bundle    (push_bundle)
	);

	stl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_bundle),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	stl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.tok       (tok)
	);

	// Unpack the result word onto the output ports
	assign kind          = tok.kind;
	assign token_line    = tok.line;
	assign token_column  = tok.column;
	assign start_offset  = tok.offset;
	assign source_length = tok.length;
	assign data_byte     = tok.data;
	assign data_valid    = tok.dvalid;
	assign last          = tok.last;

endmodule

// ----- rtl/core/stl_front.sv -----
// Front end: scans one byte per word, keeps lexer state, builds result bundles.
module stl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       text_byte,
	output logic             push,
	output stl_pkg::bundle_t bundle
);

	typedef enum logic [2:0] {
		M_IDLE, M_OP, M_IDENT, M_INT, M_DOT, M_FRAC, M_STRING, M_COMMENT
	} mode_t;

	mode_t              mode_q, mode_n;
	logic [7:0]         pend_q, pend_n;
	logic               esc_q, esc_n;
	logic [63:0]        word_q, word_n;
	logic [3:0]         wlen_q, wlen_n;
	stl_pkg::line_t     line_q, line_n, col_q, col_n;
	stl_pkg::off_t      off_q, off_n;
	stl_pkg::line_t     sline_q, sline_n, scol_q, scol_n;
	stl_pkg::off_t      spos_q, spos_n;
	stl_pkg::nest_t     paren_q, paren_n, brace_q, brace_n, brack_q, brack_n;
	logic               lstart_q, lstart_n;

	stl_pkg::tok_t [stl_pkg::ITEMS_MAX-1:0] items;
	logic [1:0]         cnt;
	logic               used;
	stl_pkg::off_t      pos, dpos;
	stl_pkg::offx_t     pos1;
	logic [7:0]         b, second;
	stl_pkg::kind_t     k1, k2, sk;
	logic               is_digit, is_alpha, is_word, in_nest;

	// Classify the byte and work out next state and results
	always_comb begin
		b        = text_byte;
		mode_n   = mode_q;
		pend_n   = pend_q;
		esc_n    = esc_q;
		word_n   = word_q;
		wlen_n   = wlen_q;
		sline_n  = sline_q;
		scol_n   = scol_q;
		spos_n   = spos_q;
		paren_n  = paren_q;
		brace_n  = brace_q;
		brack_n  = brack_q;
		lstart_n = lstart_q;
		items    = '0;
		cnt      = 2'd0;
		used     = 1'b0;
		second   = "|";
		k1       = stl_pkg::K_ILLEGAL;
		k2       = stl_pkg::K_OR;
		sk       = stl_pkg::K_ILLEGAL;

		is_digit = (b >= "0") && (b <= "9");
		is_alpha = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
		is_word  = is_digit || is_alpha || (b == "_");
		in_nest  = (paren_q != '0) || (brace_q != '0) || (brack_q != '0);

		pos   = off_q;
		pos1  = {1'b0, off_q} + stl_pkg::offx_t'(1);
		dpos  = (off_q != '0) ? off_q - stl_pkg::off_t'(1) : '0;
		off_n = (off_q == '1) ? off_q : off_q + stl_pkg::off_t'(1);
		if (b == 8'h0a) begin
			line_n = (line_q == '1) ? line_q : line_q + stl_pkg::line_t'(1);
			col_n  = '0;
		end else begin
			line_n = line_q;
			col_n  = (col_q == '1) ? col_q : col_q + stl_pkg::line_t'(1);
		end

		// Finish or extend the pending token
		case (mode_q)
			M_OP: begin
				case (pend_q)
					"=": begin second = "="; k1 = stl_pkg::K_ASSIGN; k2 = stl_pkg::K_EQ; end
					"+": begin second = "+"; k1 = stl_pkg::K_PLUS; k2 = stl_pkg::K_PLUS; end
					"-": begin second = "-"; k1 = stl_pkg::K_MINUS; k2 = stl_pkg::K_MINUS; end
					"!": begin second = "="; k1 = stl_pkg::K_NOT; k2 = stl_pkg::K_NEQ; end
					"<": begin second = "="; k1 = stl_pkg::K_LT; k2 = stl_pkg::K_LTE; end
					">": begin second = "="; k1 = stl_pkg::K_GT; k2 = stl_pkg::K_GTE; end
					"&": begin second = "&"; k1 = stl_pkg::K_ILLEGAL; k2 = stl_pkg::K_AND; end
					default: begin second = "|"; k1 = stl_pkg::K_ILLEGAL; k2 = stl_pkg::K_OR; end
				endcase
				if (b == second) begin
					items[cnt] = stl_pkg::mk_tok(k2, sline_q, scol_q, spos_q,
						stl_pkg::tok_len(pos1, spos_q), 8'd0, 1'b0, 1'b1);
					used = 1'b1;
				end else begin
					items[cnt] = stl_pkg::mk_tok(k1, sline_q, scol_q, spos_q,
						stl_pkg::tok_len({1'b0, pos}, spos_q), 8'd0, 1'b0, 1'b1);
				end
				cnt    = cnt + 2'd1;
				mode_n = M_IDLE;
			end
			M_IDENT: begin
				if (is_word) begin
					for (int i = 0; i < 8; i++) begin
						if (wlen_q == 4'(i))
							word_n[8*i +: 8] = word_q[8*i +: 8] | b;
					end
					if (wlen_q != 4'd15)
						wlen_n = wlen_q + 4'd1;
					used = 1'b1;
				end else begin
					items[cnt] = stl_pkg::mk_tok(stl_pkg::word_kind(word_q, wlen_q), sline_q,
						scol_q, spos_q, stl_pkg::tok_len({1'b0, pos}, spos_q), 8'd0, 1'b0, 1'b1);
					cnt    = cnt + 2'd1;
					mode_n = M_IDLE;
				end
			end
			M_INT: begin
				if (is_digit) begin
					used = 1'b1;
				end else if (b == ".") begin
					mode_n = M_DOT;
					used   = 1'b1;
				end else begin
					items[cnt] = stl_pkg::mk_tok(stl_pkg::K_INT, sline_q, scol_q, spos_q,
						stl_pkg::tok_len({1'b0, pos}, spos_q), 8'd0, 1'b0, 1'b1);
					cnt    = cnt + 2'd1;
					mode_n = M_IDLE;
				end
			end
			M_DOT: begin
				if (is_digit) begin
					mode_n = M_FRAC;
					used   = 1'b1;
				end else begin
					items[0] = stl_pkg::mk_tok(stl_pkg::K_INT, sline_q, scol_q, spos_q,
						stl_pkg::tok_len({1'b0, dpos}, spos_q), 8'd0, 1'b0, 1'b1);
					items[1] = stl_pkg::mk_tok(stl_pkg::K_DOT, line_q, col_q, dpos,
						stl_pkg::off_t'(1), 8'd0, 1'b0, 1'b1);
					cnt    = 2'd2;
					mode_n = M_IDLE;
				end
			end
			M_FRAC: begin
				if (is_digit) begin
					used = 1'b1;
				end else begin
					items[cnt] = stl_pkg::mk_tok(stl_pkg::K_FLOAT, sline_q, scol_q, spos_q,
						stl_pkg::tok_len({1'b0, pos}, spos_q), 8'd0, 1'b0, 1'b1);
					cnt    = cnt + 2'd1;
					mode_n = M_IDLE;
				end
			end
			M_STRING: begin
				if (esc_q) begin
					esc_n = 1'b0;
					if (b == 8'd0) begin
						items[cnt] = stl_pkg::mk_tok(stl_pkg::K_STRING, sline_q, scol_q, spos_q,
							stl_pkg::tok_len({1'b0, pos}, spos_q), 8'd0, 1'b0, 1'b1);
						cnt    = cnt + 2'd1;
						mode_n = M_IDLE;
					end else begin
						items[cnt] = stl_pkg::mk_tok(stl_pkg::K_STRING, sline_q, scol_q, spos_q,
							stl_pkg::tok_len(pos1, spos_q),
							(b == "n") ? 8'h0a : (b == "r") ? 8'h0d : (b == "t") ? 8'h09 : b,
							1'b1, 1'b0);
						cnt  = cnt + 2'd1;
						used = 1'b1;
					end
				end else if (b == 8'h22) begin
					items[cnt] = stl_pkg::mk_tok(stl_pkg::K_STRING, sline_q, scol_q, spos_q,
						stl_pkg::tok_len(pos1, spos_q), 8'd0, 1'b0, 1'b1);
					cnt    = cnt + 2'd1;
					mode_n = M_IDLE;
					used   = 1'b1;
				end else if ((b == 8'd0) || (b == 8'h0a)) begin
					items[cnt] = stl_pkg::mk_tok(stl_pkg::K_STRING, sline_q, scol_q, spos_q,
						stl_pkg::tok_len({1'b0, pos}, spos_q), 8'd0, 1'b0, 1'b1);
					cnt    = cnt + 2'd1;
					mode_n = M_IDLE;
				end else if (b == 8'h5c) begin
					esc_n = 1'b1;
					used  = 1'b1;
				end else begin
					items[cnt] = stl_pkg::mk_tok(stl_pkg::K_STRING, sline_q, scol_q, spos_q,
						stl_pkg::tok_len(pos1, spos_q), b, 1'b1, 1'b0);
					cnt  = cnt + 2'd1;
					used = 1'b1;
				end
			end
			M_COMMENT: begin
				if ((b == 8'd0) || (b == 8'h0a))
					mode_n = M_IDLE;
				else
					used = 1'b1;
			end
			default: begin
				mode_n = M_IDLE;
			end
		endcase

		// Start a new token, or handle end of text, blanks and newlines
		if (!used) begin
			if (b == 8'd0) begin
				items[cnt] = stl_pkg::mk_tok(stl_pkg::K_END, line_n, col_n, pos, '0,
					8'd0, 1'b0, 1'b1);
				cnt      = cnt + 2'd1;
				mode_n   = M_IDLE;
				pend_n   = '0;
				esc_n    = 1'b0;
				word_n   = '0;
				wlen_n   = '0;
				line_n   = stl_pkg::line_t'(1);
				col_n    = '0;
				off_n    = '0;
				sline_n  = stl_pkg::line_t'(1);
				scol_n   = '0;
				spos_n   = '0;
				paren_n  = '0;
				brace_n  = '0;
				brack_n  = '0;
				lstart_n = 1'b1;
			end else if ((b == " ") || (b == 8'h09) || (b == 8'h0d)) begin
				lstart_n = lstart_q;
			end else if (b == 8'h0a) begin
				if (!in_nest && !lstart_q) begin
					lstart_n   = 1'b1;
					items[cnt] = stl_pkg::mk_tok(stl_pkg::K_NEWLINE, line_n, '0, pos,
						stl_pkg::off_t'(1), 8'd0, 1'b0, 1'b1);
					cnt        = cnt + 2'd1;
				end
			end else begin
				lstart_n = 1'b0;
				sline_n  = line_n;
				scol_n   = col_n;
				spos_n   = pos;
				case (b)
					"=", "+", "-", "!", "<", ">", "&", "|": begin
						mode_n = M_OP;
						pend_n = b;
					end
					"*": sk = stl_pkg::K_STAR;
					"/": sk = stl_pkg::K_SLASH;
					"%": sk = stl_pkg::K_PERCENT;
					"(": begin
						sk = stl_pkg::K_LPAREN;
						if (paren_q != '1) paren_n = paren_q + stl_pkg::nest_t'(1);
					end
					")": begin
						sk = stl_pkg::K_RPAREN;
						if (paren_q != '0) paren_n = paren_q - stl_pkg::nest_t'(1);
					end
					"{": begin
						sk = stl_pkg::K_LBRACE;
						if (brace_q != '1) brace_n = brace_q + stl_pkg::nest_t'(1);
					end
					"}": begin
						sk = stl_pkg::K_RBRACE;
						if (brace_q != '0) brace_n = brace_q - stl_pkg::nest_t'(1);
					end
					"[": begin
						sk = stl_pkg::K_LBRACKET;
						if (brack_q != '1) brack_n = brack_q + stl_pkg::nest_t'(1);
					end
					"]": begin
						sk = stl_pkg::K_RBRACKET;
						if (brack_q != '0) brack_n = brack_q - stl_pkg::nest_t'(1);
					end
					",": sk = stl_pkg::K_COMMA;
					".": sk = stl_pkg::K_DOT;
					":": sk = stl_pkg::K_COLON;
					";": sk = stl_pkg::K_SEMICOLON;
					8'h22: begin
						mode_n = M_STRING;
						esc_n  = 1'b0;
					end
					"~", "#": mode_n = M_COMMENT;
					default: begin
						if (is_alpha || (b == "_")) begin
							mode_n = M_IDENT;
							word_n = {56'd0, b};
							wlen_n = 4'd1;
						end else if (is_digit) begin
							mode_n = M_INT;
						end
					end
				endcase
				// Single-byte tokens close right here
				if ((mode_n == M_IDLE)) begin
					items[cnt] = stl_pkg::mk_tok(sk, line_n, col_n, pos,
						stl_pkg::tok_len(pos1, pos), 8'd0, 1'b0, 1'b1);
					cnt        = cnt + 2'd1;
				end
			end
		end
	end

	assign push          = accept && (cnt != 2'd0);
	assign bundle.count  = cnt;
	assign bundle.items  = items;

	// Hold lexer state, advance on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pend_q   <= '0;
			esc_q    <= 1'b0;
			word_q   <= '0;
			wlen_q   <= '0;
			line_q   <= stl_pkg::line_t'(1);
			col_q    <= '0;
			off_q    <= '0;
			sline_q  <= stl_pkg::line_t'(1);
			scol_q   <= '0;
			spos_q   <= '0;
			paren_q  <= '0;
			brace_q  <= '0;
			brack_q  <= '0;
			lstart_q <= 1'b1;
		end else if (accept) begin
			mode_q   <= mode_n;
			pend_q   <= pend_n;
			esc_q    <= esc_n;
			word_q   <= word_n;
			wlen_q   <= wlen_n;
			line_q   <= line_n;
			col_q    <= col_n;
			off_q    <= off_n;
			sline_q  <= sline_n;
			scol_q   <= scol_n;
			spos_q   <= spos_n;
			paren_q  <= paren_n;
			brace_q  <= brace_n;
			brack_q  <= brack_n;
			lstart_q <= lstart_n;
		end
	end

	// End of text returns the scanner to its reset state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (text_byte == 8'd0)) |=>
		(mode_q == M_IDLE) && (line_q == stl_pkg::line_t'(1)) && (off_q == '0))
		else $error("end of text did not clear scanner state");

	a_esc_in_string: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> (mode_q == M_STRING))
		else $error("escape pending outside a string");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line counter reached zero");

endmodule

// ----- rtl/core/stl_queue.sv -----
// Short bundle queue between the scanner and the result serializer.
module stl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  stl_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output stl_pkg::bundle_t head,
	output logic             empty
);

	stl_pkg::bundle_t               mem_q [stl_pkg::QUEUE_DEPTH];
	logic [stl_pkg::QPTR_BITS-1:0]  wr_q, rd_q;
	logic [stl_pkg::QPTR_BITS:0]    count_q;

	assign full  = (count_q == (stl_pkg::QPTR_BITS+1)'(stl_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	// Store pushed bundles
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + stl_pkg::QPTR_BITS'(1);
			if (pop)
				rd_q <= rd_q + stl_pkg::QPTR_BITS'(1);
			if (push && !pop)
				count_q <= count_q + (stl_pkg::QPTR_BITS+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (stl_pkg::QPTR_BITS+1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (stl_pkg::QPTR_BITS+1)'(stl_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

// ----- rtl/core/stl_back.sv -----
// Back end: walks each bundle and hands out one result word per cycle while out_stall is low.
module stl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  stl_pkg::bundle_t head,
	input  logic             empty,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output stl_pkg::tok_t    tok
);

	logic [1:0]    idx_q;
	logic          valid_q;
	stl_pkg::tok_t tok_q;
	logic          load, final_item;

	assign load       = !empty && (!valid_q || !out_stall);
	assign final_item = (idx_q == (head.count - 2'd1));
	assign pop        = load && final_item;
	assign out_valid  = valid_q;
	assign tok        = tok_q;

	// Hold payload while stalled, load the next word when the queue has one
	always_ff @(posedge clk) begin
		if (load)
			tok_q <= head.items[idx_q];
	end

	// Advance item index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_item ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_mid_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> !empty)
		else $error("bundle index set with empty queue");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (idx_q < head.count))
		else $error("bundle index past item count");

	a_pop_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("bundle dropped without output");

endmodule

// ----- bench/script_token_lexer_tb.sv -----
// Self-checking bench for the streaming lexer: byte stimulus, token prediction, word compare.
module script_token_lexer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_MODE = 0, OP_MODE = 1, WORD_MODE = 2, INT_MODE = 3, DOT_MODE = 4;
	localparam int FRAC_MODE = 5, STR_MODE = 6, NOTE_MODE = 7;
	localparam int STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  kind;
	logic [15:0] token_line, token_column;
	logic [19:0] start_offset, source_length;
	logic [7:0]  data_byte;
	logic        data_valid, last;

	script_token_lexer dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// lexer state mirror
	int          lx_mode;
	logic [7:0]  lx_pend;
	logic        lx_esc;
	logic [63:0] lx_word;
	int          lx_wlen;
	longint      lx_line, lx_col, lx_off, lx_sline, lx_scol, lx_spos;
	longint      lx_paren, lx_brace, lx_brack;
	logic        lx_bol;

	stl_pkg::tok_t token_queue[$];
	int   mismatches = 0;
	int   tokens_seen = 0;
	int   idle_cycles = 0;
	bit   hold_off = 0;
	bit   rx_gaps = 1;

	function automatic longint sat(longint v, int bits);
		return (v < (64'd1 << bits) - 1) ? v + 1 : v;
	endfunction

	function automatic void lexer_clear();
		lx_mode = IDLE_MODE; lx_pend = 0; lx_esc = 0; lx_word = 0; lx_wlen = 0;
		lx_line = 1; lx_col = 0; lx_off = 0; lx_sline = 1; lx_scol = 0; lx_spos = 0;
		lx_paren = 0; lx_brace = 0; lx_brack = 0; lx_bol = 1;
	endfunction

	function automatic void push_word(stl_pkg::kind_t k, longint ln, longint col, longint off,
			longint len, logic [7:0] d, bit dv, bit lst);
		stl_pkg::tok_t t;
		t.kind = k; t.line = stl_pkg::line_t'(ln); t.column = stl_pkg::line_t'(col);
		t.offset = stl_pkg::off_t'(off);
		t.length = (len > 64'hFFFFF) ? '1 : stl_pkg::off_t'(len);
		t.data = d; t.dvalid = dv; t.last = lst;
		token_queue.push_back(t);
	endfunction

	function automatic void push_tok(stl_pkg::kind_t k, longint end_pos);
		push_word(k, lx_sline, lx_scol, lx_spos, (end_pos >= lx_spos) ? end_pos - lx_spos : 0,
			8'd0, 0, 1);
	endfunction

	function automatic bit is_dig(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_alp(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic stl_pkg::kind_t keyword_of();
		string names[17] = '{"say", "val", "let", "func", "if", "else", "loop", "while",
			"in", "to", "return", "closc", "for", "break", "continue", "true", "false"};
		stl_pkg::kind_t codes[17] = '{stl_pkg::K_SAY, stl_pkg::K_VAL, stl_pkg::K_LET,
			stl_pkg::K_FUNC, stl_pkg::K_IF, stl_pkg::K_ELSE, stl_pkg::K_LOOP, stl_pkg::K_WHILE,
			stl_pkg::K_IN, stl_pkg::K_TO, stl_pkg::K_RETURN, stl_pkg::K_CLOSC, stl_pkg::K_FOR,
			stl_pkg::K_BREAK, stl_pkg::K_CONTINUE, stl_pkg::K_BOOL, stl_pkg::K_BOOL};
		logic [63:0] p;
		if (lx_wlen > stl_pkg::KEYWORD_MAX) return stl_pkg::K_IDENT;
		for (int i = 0; i < 17; i++) begin
			p = 0;
			for (int j = 0; j < names[i].len(); j++) p[8*j +: 8] = names[i][j];
			if (names[i].len() == lx_wlen && p == lx_word) return codes[i];
		end
		return stl_pkg::K_IDENT;
	endfunction

	// predict the words caused by one source byte
	function automatic void lex_byte(logic [7:0] b);
		longint pos, pl, pc, ln, col, dp;
		bit used;
		logic [7:0] sec, d;
		stl_pkg::kind_t k1, k2;
		pos = lx_off; pl = lx_line; pc = lx_col; used = 0;
		lx_off = sat(lx_off, stl_pkg::OFFSET_BITS);
		if (b == 8'h0A) begin
			lx_line = sat(lx_line, stl_pkg::LINE_BITS); lx_col = 0;
		end else lx_col = sat(lx_col, stl_pkg::LINE_BITS);
		ln = lx_line; col = lx_col;
		case (lx_mode)
			OP_MODE: begin
				case (lx_pend)
					"=": begin sec = "="; k1 = stl_pkg::K_ASSIGN; k2 = stl_pkg::K_EQ; end
					"+": begin sec = "+"; k1 = stl_pkg::K_PLUS; k2 = stl_pkg::K_PLUS; end
					"-": begin sec = "-"; k1 = stl_pkg::K_MINUS; k2 = stl_pkg::K_MINUS; end
					"!": begin sec = "="; k1 = stl_pkg::K_NOT; k2 = stl_pkg::K_NEQ; end
					"<": begin sec = "="; k1 = stl_pkg::K_LT; k2 = stl_pkg::K_LTE; end
					">": begin sec = "="; k1 = stl_pkg::K_GT; k2 = stl_pkg::K_GTE; end
					"&": begin sec = "&"; k1 = stl_pkg::K_ILLEGAL; k2 = stl_pkg::K_AND; end
					default: begin sec = "|"; k1 = stl_pkg::K_ILLEGAL; k2 = stl_pkg::K_OR; end
				endcase
				if (b == sec) begin
					push_tok(k2, pos + 1); used = 1;
				end else push_tok(k1, pos);
				lx_mode = IDLE_MODE;
			end
			WORD_MODE: begin
				if (is_alp(b) || is_dig(b) || b == "_") begin
					if (lx_wlen < 8) lx_word[8*lx_wlen +: 8] = b;
					if (lx_wlen < 15) lx_wlen++;
					used = 1;
				end else begin
					push_tok(keyword_of(), pos); lx_mode = IDLE_MODE;
				end
			end
			INT_MODE: begin
				if (is_dig(b)) used = 1;
				else if (b == ".") begin
					lx_mode = DOT_MODE; used = 1;
				end else begin
					push_tok(stl_pkg::K_INT, pos); lx_mode = IDLE_MODE;
				end
			end
			DOT_MODE: begin
				if (is_dig(b)) begin
					lx_mode = FRAC_MODE; used = 1;
				end else begin
					dp = (pos > 0) ? pos - 1 : 0;
					push_tok(stl_pkg::K_INT, dp);
					push_word(stl_pkg::K_DOT, pl, pc, dp, 1, 8'd0, 0, 1);
					lx_mode = IDLE_MODE;
				end
			end
			FRAC_MODE: begin
				if (is_dig(b)) used = 1;
				else begin
					push_tok(stl_pkg::K_FLOAT, pos); lx_mode = IDLE_MODE;
				end
			end
			STR_MODE: begin
				if (lx_esc) begin
					lx_esc = 0;
					if (b == 0) begin
						push_tok(stl_pkg::K_STRING, pos); lx_mode = IDLE_MODE;
					end else begin
						d = (b == "n") ? 8'h0A : (b == "r") ? 8'h0D : (b == "t") ? 8'h09 : b;
						push_word(stl_pkg::K_STRING, lx_sline, lx_scol, lx_spos,
							pos + 1 - lx_spos, d, 1, 0);
						used = 1;
					end
				end else if (b == 8'h22) begin
					push_tok(stl_pkg::K_STRING, pos + 1); lx_mode = IDLE_MODE; used = 1;
				end else if (b == 0 || b == 8'h0A) begin
					push_tok(stl_pkg::K_STRING, pos); lx_mode = IDLE_MODE;
				end else if (b == 8'h5C) begin
					lx_esc = 1; used = 1;
				end else begin
					push_word(stl_pkg::K_STRING, lx_sline, lx_scol, lx_spos,
						pos + 1 - lx_spos, b, 1, 0);
					used = 1;
				end
			end
			NOTE_MODE: begin
				if (b == 0 || b == 8'h0A) lx_mode = IDLE_MODE;
				else used = 1;
			end
			default: lx_mode = IDLE_MODE;
		endcase
		if (used) return;
		if (b == 0) begin
			push_word(stl_pkg::K_END, ln, col, pos, 0, 8'd0, 0, 1);
			lexer_clear();
			return;
		end
		if (b == " " || b == 8'h09 || b == 8'h0D) return;
		if (b == 8'h0A) begin
			if (lx_paren == 0 && lx_brace == 0 && lx_brack == 0 && !lx_bol) begin
				lx_bol = 1;
				push_word(stl_pkg::K_NEWLINE, ln, 0, pos, 1, 8'd0, 0, 1);
			end
			return;
		end
		lx_bol = 0;
		lx_sline = ln; lx_scol = col; lx_spos = pos;
		case (b)
			"=", "+", "-", "!", "<", ">", "&", "|": begin lx_mode = OP_MODE; lx_pend = b; end
			"*": push_tok(stl_pkg::K_STAR, pos + 1);
			"/": push_tok(stl_pkg::K_SLASH, pos + 1);
			"%": push_tok(stl_pkg::K_PERCENT, pos + 1);
			"(": begin
				lx_paren = sat(lx_paren, stl_pkg::NEST_BITS);
				push_tok(stl_pkg::K_LPAREN, pos + 1);
			end
			")": begin if (lx_paren > 0) lx_paren--; push_tok(stl_pkg::K_RPAREN, pos + 1); end
			"{": begin
				lx_brace = sat(lx_brace, stl_pkg::NEST_BITS);
				push_tok(stl_pkg::K_LBRACE, pos + 1);
			end
			"}": begin if (lx_brace > 0) lx_brace--; push_tok(stl_pkg::K_RBRACE, pos + 1); end
			"[": begin
				lx_brack = sat(lx_brack, stl_pkg::NEST_BITS);
				push_tok(stl_pkg::K_LBRACKET, pos + 1);
			end
			"]": begin if (lx_brack > 0) lx_brack--; push_tok(stl_pkg::K_RBRACKET, pos + 1); end
			",": push_tok(stl_pkg::K_COMMA, pos + 1);
			".": push_tok(stl_pkg::K_DOT, pos + 1);
			":": push_tok(stl_pkg::K_COLON, pos + 1);
			";": push_tok(stl_pkg::K_SEMICOLON, pos + 1);
			8'h22: begin lx_mode = STR_MODE; lx_esc = 0; end
			"~", "#": lx_mode = NOTE_MODE;
			default: begin
				if (is_alp(b) || b == "_") begin
					lx_mode = WORD_MODE; lx_word = 64'(b); lx_wlen = 1;
				end else if (is_dig(b)) lx_mode = INT_MODE;
				else push_tok(stl_pkg::K_ILLEGAL, pos + 1);
			end
		endcase
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
	endfunction

	// offer one byte and hold it until the block takes it
	task automatic send_byte(logic [7:0] b, bit gaps = 1);
		int g;
		g = gaps ? gap_len() : 0;
		if ($urandom_range(0, 1) == 0) g = 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		lex_byte(b);
	endtask

	task automatic send_text(string s, bit gaps = 1);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], gaps);
	endtask

	// drop the input and wait for every predicted word
	task automatic drain();
		in_valid <= 1'b0;
		while (token_queue.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// compare every accepted word with the oldest prediction
	always @(posedge clk) begin
		stl_pkg::tok_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			tokens_seen++;
			if (token_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word kind=%0d", kind);
			end else begin
				exp_w = token_queue.pop_front();
				if (kind !== exp_w.kind || token_line !== exp_w.line ||
						token_column !== exp_w.column || start_offset !== exp_w.offset ||
						source_length !== exp_w.length || data_byte !== exp_w.data ||
						data_valid !== exp_w.dvalid || last !== exp_w.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch: exp k%0d l%0d c%0d o%0d n%0d d%0h v%0b e%0b, got k%0d l%0d c%0d o%0d n%0d d%0h v%0b e%0b",
							exp_w.kind, exp_w.line, exp_w.column, exp_w.offset, exp_w.length,
							exp_w.data, exp_w.dvalid, exp_w.last, kind, token_line,
							token_column, start_offset, source_length, data_byte,
							data_valid, last);
				end
			end
		end
	end

	// receiver stall: random gaps, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else if (!rx_gaps) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 2) == 0);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic test_operators();
		send_text("=a==+ ++-!=<>&&|*/%,:;\n");
	endtask

	task automatic test_words_numbers();
		send_text("closc continue9 7.x 8.\n");
	endtask

	task automatic test_strings_comments();
		send_text("\"a\\n\\q\" \"b\n# c\n");
		send_byte(8'h22); send_byte(8'h5C); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'h01); send_byte(8'h00);
	endtask

	task automatic test_nesting();
		send_text("(\n)]\n 1\n");
		send_byte(8'h80); send_byte(8'h00);
	endtask

	// long receiver hold-off so the queue fills and the input stalls
	task automatic test_backpressure();
		int n;
		drain();
		hold_off = 1;
		fork
			begin
				n = 0;
				while (n < 200) begin @(posedge clk); n++; end
				hold_off = 0;
			end
			send_text("(a)(b)\"xyz\"", 0);
		join
		drain();
	endtask

	task automatic test_random_text();
		string frags[14] = '{"let ", "x1", " = ", "42", "3.14", "\"s\\n\"", "(", ")", "{\n",
			"}\n", "# c\n", "\n", "while ", "+= "};
		int sel;
		for (int i = 0; i < 5; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 7) send_text(frags[$urandom_range(0, 13)]);
			else if (sel < 9) send_byte(8'($urandom_range(32, 126)));
			else send_byte(8'($urandom_range(0, 255)));
		end
		send_byte(8'h00);
	endtask

	initial begin
		lexer_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operators();
		test_words_numbers();
		test_strings_comments();
		test_nesting();
		test_backpressure();
		rx_gaps = 0;
		test_random_text();
		rx_gaps = 1;
		test_random_text();
		drain();
		$display("Covered operators, keywords, numbers, strings, comments, nesting and");
		$display("end-of-text flushes under random gaps and a long output hold-off: %0d words.",
			tokens_seen);
		if (mismatches == 0 && token_queue.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
